@@ hdl/bbn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounding box normalizer package
// Shared widths, action codes and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package bbn_pkg;

  localparam int unsigned COORD_WIDTH_DEF   = 16;
  localparam int unsigned OUT_FRAC_BITS_DEF = 14;
  localparam int unsigned OUT_WIDTH         = 16;
  localparam int unsigned ACT_WIDTH         = 2;
  localparam int unsigned AXES              = 3;

  typedef enum logic [ACT_WIDTH-1:0] {
    ACT_CLEAR     = 2'd0,
    ACT_OBSERVE   = 2'd1,
    ACT_NORMALIZE = 2'd2
  } action_e;

  typedef struct packed {
    logic clear;
    logic observe;
    logic capture;
    logic prep;
    logic div_step;
    logic load_out;
  } bbn_cmd_t;

  typedef struct packed {
    logic out_free;
  } bbn_status_t;

endpackage

@@ hdl/bbn_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounding box normalizer channels
// Point channel into the block and result channel out of it, each with a
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface bbn_in_if
  import bbn_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic [ACT_WIDTH-1:0]          action;
  logic signed [COORD_WIDTH-1:0] x_coord;
  logic signed [COORD_WIDTH-1:0] y_coord;
  logic signed [COORD_WIDTH-1:0] z_coord;

  modport source (output valid, action, x_coord, y_coord, z_coord, input ready);
  modport sink   (input valid, action, x_coord, y_coord, z_coord, output ready);
endinterface

interface bbn_out_if
  import bbn_pkg::*;
();
  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] norm_x;
  logic signed [OUT_WIDTH-1:0] norm_y;
  logic signed [OUT_WIDTH-1:0] norm_z;
  logic                        empty_cloud;
  logic                        degenerate;

  modport source (output valid, norm_x, norm_y, norm_z, empty_cloud, degenerate,
                  input ready);
  modport sink   (input valid, norm_x, norm_y, norm_z, empty_cloud, degenerate,
                  output ready);
endinterface

@@ hdl/bbn_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounding box normalizer controller
// Accepts beats, decodes the action and sequences the preparation, the
// division steps and the hand-off into the output register.
// ----------------------------------------------------------------------------
module bbn_ctrl
  import bbn_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [ACT_WIDTH-1:0] in_action_i,
  input  bbn_status_t          status_i,
  output logic                 in_ready_o,
  output bbn_cmd_t             cmd_o
);

  localparam int unsigned CNT_W = $clog2(OUT_WIDTH);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_action_i)
            ACT_CLEAR:   cmd_o.clear   = 1'b1;
            ACT_OBSERVE: cmd_o.observe = 1'b1;
            ACT_NORMALIZE: begin
              cmd_o.capture = 1'b1;
              state_d       = S_PREP;
            end
            default: ;
          endcase
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = CNT_W'(OUT_WIDTH - 1);
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_DONE: begin
        // Wait until the output register is empty or being drained.
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

@@ hdl/bbn_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounding box normalizer datapath
// Holds the box, prepares numerators and the scale, runs three restoring
// dividers side by side and keeps the saturated result in an output register.
// ----------------------------------------------------------------------------
module bbn_dp
  import bbn_pkg::*;
#(
  parameter int unsigned COORD_WIDTH   = COORD_WIDTH_DEF,
  parameter int unsigned OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bbn_cmd_t                      cmd_i,
  input  logic signed [COORD_WIDTH-1:0] x_i,
  input  logic signed [COORD_WIDTH-1:0] y_i,
  input  logic signed [COORD_WIDTH-1:0] z_i,
  input  logic                          out_ready_i,
  output bbn_status_t                   status_o,
  output logic                          out_valid_o,
  output logic signed [OUT_WIDTH-1:0]   norm_x_o,
  output logic signed [OUT_WIDTH-1:0]   norm_y_o,
  output logic signed [OUT_WIDTH-1:0]   norm_z_o,
  output logic                          empty_o,
  output logic                          degen_o
);

  localparam int unsigned NW   = COORD_WIDTH + 2;
  localparam int unsigned DW_A = NW + OUT_FRAC_BITS;
  localparam int unsigned DW_B = COORD_WIDTH + OUT_WIDTH - 1;
  localparam int unsigned DW   = (DW_A > DW_B) ? DW_A : DW_B;
  localparam logic [OUT_WIDTH-1:0] OUT_MAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};
  localparam logic [OUT_WIDTH-1:0] OUT_MIN = {1'b1, {(OUT_WIDTH-1){1'b0}}};

  logic signed [COORD_WIDTH-1:0] pt_in [AXES];
  logic signed [COORD_WIDTH-1:0] pt_q  [AXES];
  logic signed [COORD_WIDTH-1:0] lo_q  [AXES];
  logic signed [COORD_WIDTH-1:0] hi_q  [AXES];
  logic [COORD_WIDTH:0]          ext_full [AXES];
  logic [COORD_WIDTH-1:0]        ext   [AXES];
  logic [NW-1:0]                 num   [AXES];
  logic [NW-1:0]                 mag   [AXES];
  logic [COORD_WIDTH-1:0]        scale;
  logic [DW-1:0]                 rem_q [AXES];
  logic [DW:0]                   diff  [AXES];
  logic [OUT_WIDTH-1:0]          quo_q [AXES];
  logic [OUT_WIDTH-1:0]          sat   [AXES];
  logic                          neg_q [AXES];
  logic [DW-1:0]                 dvs_q;
  logic                          have_q, empty_q, degen_q, out_valid_q;
  logic [OUT_WIDTH-1:0]          norm_q [AXES];
  logic                          out_empty_q, out_degen_q;

  assign pt_in[0] = x_i;
  assign pt_in[1] = y_i;
  assign pt_in[2] = z_i;

  // Extents, numerators 2p - lo - hi and their magnitudes.
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      ext_full[a] = {hi_q[a][COORD_WIDTH-1], hi_q[a]} - {lo_q[a][COORD_WIDTH-1], lo_q[a]};
      ext[a]      = ext_full[a][COORD_WIDTH-1:0];
      num[a]      = {pt_q[a][COORD_WIDTH-1], pt_q[a], 1'b0}
                  - {{2{lo_q[a][COORD_WIDTH-1]}}, lo_q[a]}
                  - {{2{hi_q[a][COORD_WIDTH-1]}}, hi_q[a]};
      mag[a]      = num[a][NW-1] ? (~num[a] + 1'b1) : num[a];
      diff[a]     = {1'b0, rem_q[a]} - {1'b0, dvs_q};
    end
  end

  always_comb begin
    scale = ext[0];
    if (ext[1] > scale) scale = ext[1];
    if (ext[2] > scale) scale = ext[2];
  end

  // The top quotient bit set means the true quotient reaches the output range
  // limit, so the remaining bits no longer matter.
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      if (neg_q[a]) begin
        sat[a] = quo_q[a][OUT_WIDTH-1] ? OUT_MIN : (~quo_q[a] + 1'b1);
      end else begin
        sat[a] = quo_q[a][OUT_WIDTH-1] ? OUT_MAX : quo_q[a];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.observe) begin
      for (int a = 0; a < AXES; a++) begin
        if (!have_q || pt_in[a] < lo_q[a]) lo_q[a] <= pt_in[a];
        if (!have_q || pt_in[a] > hi_q[a]) hi_q[a] <= pt_in[a];
      end
    end
    if (cmd_i.capture) begin
      for (int a = 0; a < AXES; a++) pt_q[a] <= pt_in[a];
    end
    if (cmd_i.prep) begin
      for (int a = 0; a < AXES; a++) begin
        rem_q[a] <= DW'({mag[a], {OUT_FRAC_BITS{1'b0}}});
        neg_q[a] <= num[a][NW-1];
        quo_q[a] <= '0;
      end
      dvs_q   <= DW'({scale, {(OUT_WIDTH-1){1'b0}}});
      empty_q <= !have_q;
      degen_q <= (scale == '0);
    end
    if (cmd_i.div_step) begin
      for (int a = 0; a < AXES; a++) begin
        if (!diff[a][DW]) begin
          rem_q[a] <= diff[a][DW-1:0];
          quo_q[a] <= {quo_q[a][OUT_WIDTH-2:0], 1'b1};
        end else begin
          quo_q[a] <= {quo_q[a][OUT_WIDTH-2:0], 1'b0};
        end
      end
      dvs_q <= dvs_q >> 1;
    end
    if (cmd_i.load_out) begin
      for (int a = 0; a < AXES; a++) begin
        norm_q[a] <= (empty_q || degen_q) ? '0 : sat[a];
      end
      out_empty_q <= empty_q;
      out_degen_q <= !empty_q && degen_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        have_q <= 1'b0;
      end else if (cmd_i.observe) begin
        have_q <= 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign norm_x_o          = norm_q[0];
  assign norm_y_o          = norm_q[1];
  assign norm_z_o          = norm_q[2];
  assign empty_o           = out_empty_q;
  assign degen_o           = out_degen_q;

endmodule

@@ hdl/bounding_box_normalizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounding box normalizer
// Maps 3D points into the cube from -1 to 1 using the cloud's bounding box.
// ----------------------------------------------------------------------------
// Usage: each beat on in_i carries an action and a point. Clear restarts the
// box, observe widens it with the point, normalize returns one beat on out_o
// holding 2*(p - center)/scale per axis in signed Q1.OUT_FRAC_BITS, truncated
// toward zero and saturated, where scale is the largest box extent.
// A normalize before any observe returns zeros with empty_cloud set; a zero
// scale returns zeros with degenerate set.
// Clear and observe can be sent every cycle while no normalize is running.
// A normalize holds in_i.ready low while it runs: a preparation step sets up
// the numerators and the scale, then three restoring dividers run side by
// side, one quotient bit per cycle until all OUT_WIDTH bits are done. The
// result is loaded into the output register as the controller returns to
// idle, so the next beat can be taken in the cycle the result becomes valid.
// The result sits in an output register, so new beats are taken while it
// waits; a stalled receiver only holds back the next normalize at its end.
// Reset empties the box and drops any result that was waiting.
// ----------------------------------------------------------------------------
module bounding_box_normalizer
  import bbn_pkg::*;
#(
  parameter int unsigned COORD_WIDTH   = COORD_WIDTH_DEF,
  parameter int unsigned OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  bbn_in_if.sink    in_i,
  bbn_out_if.source out_o
);

  bbn_cmd_t    cmd;
  bbn_status_t status;
  logic        in_ready;

  bbn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .status_i    (status),
    .in_ready_o  (in_ready),
    .cmd_o       (cmd)
  );

  bbn_dp #(
    .COORD_WIDTH   (COORD_WIDTH),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .x_i         (in_i.x_coord),
    .y_i         (in_i.y_coord),
    .z_i         (in_i.z_coord),
    .out_ready_i (out_o.ready),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .norm_x_o    (out_o.norm_x),
    .norm_y_o    (out_o.norm_y),
    .norm_z_o    (out_o.norm_z),
    .empty_o     (out_o.empty_cloud),
    .degen_o     (out_o.degenerate)
  );

  assign in_i.ready = in_ready;

endmodule

@@ hdl/bbn_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounding box normalizer checker
// Watches the top level's channels and checks result flags and sequencing.
// ----------------------------------------------------------------------------
module bbn_chk
  import bbn_pkg::*;
(
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic [ACT_WIDTH-1:0]        in_action_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic signed [OUT_WIDTH-1:0] norm_x_i,
  input logic signed [OUT_WIDTH-1:0] norm_y_i,
  input logic signed [OUT_WIDTH-1:0] norm_z_i,
  input logic                        empty_cloud_i,
  input logic                        degenerate_i
);

  // A stalled result beat holds still.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(norm_x_i)
      && $stable(norm_y_i) && $stable(norm_z_i) && $stable(empty_cloud_i)
      && $stable(degenerate_i))
    else $error("result beat changed while stalled");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(empty_cloud_i && degenerate_i))
    else $error("empty and degenerate flags both set");

  // A flagged result carries zero coordinates.
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (empty_cloud_i || degenerate_i)
      |-> norm_x_i == '0 && norm_y_i == '0 && norm_z_i == '0)
    else $error("flagged result with nonzero coordinates");

  // A normalize beat keeps the block busy in the following cycle.
  a_norm_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_action_i == ACT_NORMALIZE |=> !in_ready_i)
    else $error("input taken right after a normalize beat");

endmodule

bind bounding_box_normalizer bbn_chk u_bbn_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_action_i   (in_i.action),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .norm_x_i      (out_o.norm_x),
  .norm_y_i      (out_o.norm_y),
  .norm_z_i      (out_o.norm_z),
  .empty_cloud_i (out_o.empty_cloud),
  .degenerate_i  (out_o.degenerate)
);
